/* hw/rtl/mms_pkg.sv */
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types and constants of the motor mode sequencer with duty ramp.
// ----------------------------------------------------------------------------
package mms_pkg;

  // configuration port widths and register indexes
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_IDX_LIGHT_THRESHOLD = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SLOW_DUTY       = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_IDX_MEDIUM_DUTY     = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_FAST_DUTY       = 4'd3;

  // register reset values
  localparam logic [9:0] LIGHT_THRESHOLD_RST = 10'd550;
  localparam logic [7:0] SLOW_DUTY_RST       = 8'd80;
  localparam logic [7:0] MEDIUM_DUTY_RST     = 8'd150;
  localparam logic [7:0] FAST_DUTY_RST       = 8'd254;

  // drive modes; code seven is unreachable and behaves as off
  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_SLOW    = 3'd1,
    MODE_MEDIUM  = 3'd2,
    MODE_FAST    = 3'd3,
    MODE_REVERSE = 3'd4,
    MODE_TURN_A  = 3'd5,
    MODE_TURN_B  = 3'd6
  } mode_e;

  // input item
  typedef struct packed {
    logic       stop_switch;
    logic       advance_press;
    logic       collision_event;
    logic [9:0] light_level;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0]  drive_mode;
    logic [7:0]  duty_level;
    logic        left_fwd_pin;
    logic        left_rev_pin;
    logic        right_fwd_pin;
    logic        right_rev_pin;
    logic        green_lamp;
    logic        red_lamp;
    logic        white_lamp;
    logic [15:0] crash_count;
  } out_item_t;

  // configuration register file contents
  typedef struct packed {
    logic [9:0] light_threshold;
    logic [7:0] slow_duty;
    logic [7:0] medium_duty;
    logic [7:0] fast_duty;
  } cfg_t;

  // sequencer state, which is also what a result shows
  typedef struct packed {
    mode_e       mode;
    logic [7:0]  duty;
    logic        left_fwd;
    logic        left_rev;
    logic        right_fwd;
    logic        right_rev;
    logic        green;
    logic        red;
    logic        white;
    logic [15:0] crash;
  } seq_state_t;

endpackage

/* hw/rtl/motor_mode_sequencer_with_ramp_core.sv */
// ----------------------------------------------------------------------------
// motor_mode_sequencer_with_ramp_core
// Motor mode sequencer: cycles drive modes and ramps the duty per tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one ramp tick per transfer (stop, advance press, collision,
//            light sample). Taken on in_valid_i && in_ready_o.
//   out_*  : one result per tick, the mode, duty, pins, lamps and crash
//            count after that tick. Taken on out_valid_o && out_ready_i.
//   cfg_*  : register writes (index 0 light threshold, 1 slow, 2 medium,
//            3 fast duty); always ready; write only while idle.
//   An input transfer reaches the result through an input register, then
//   the sequencer state register, which doubles as the result register.
//   Throughput is one tick per cycle while the receiver does not stall,
//   set by the single state update between those two registers.
//   Reset clears the mode, duty, pins and crash count, sets the white
//   lamp, and loads the register reset values; no result is pending.
//   When the receiver stalls, the result holds, one more tick waits in
//   the input register, and in_ready_o drops only when both are full.
// ----------------------------------------------------------------------------
module motor_mode_sequencer_with_ramp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mms_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mms_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mms_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mms_pkg::CfgDataW-1:0]  cfg_data_i
);

  mms_pkg::cfg_t       cfg;
  mms_pkg::in_item_t   item_q;
  logic                item_valid_d, item_valid_q;
  logic                out_valid_d, out_valid_q;
  mms_pkg::seq_state_t state_q, state_next;
  logic                fire;

  mms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mms_step_logic u_step (
    .state_i (state_q),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .state_o (state_next)
  );

  // advance a tick when the result slot is free or being emptied
  assign fire       = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || fire;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_ready_o) begin
      item_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // hold control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // capture the input transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  // update sequencer state, which is the result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= mms_pkg::MODE_OFF;
      state_q.duty      <= 8'd0;
      state_q.left_fwd  <= 1'b0;
      state_q.left_rev  <= 1'b0;
      state_q.right_fwd <= 1'b0;
      state_q.right_rev <= 1'b0;
      state_q.green     <= 1'b0;
      state_q.red       <= 1'b0;
      state_q.white     <= 1'b1;
      state_q.crash     <= 16'd0;
    end else if (fire) begin
      state_q <= state_next;
    end
  end

  // drive the result
  assign out_valid_o              = out_valid_q;
  assign out_item_o.drive_mode    = state_q.mode;
  assign out_item_o.duty_level    = state_q.duty;
  assign out_item_o.left_fwd_pin  = state_q.left_fwd;
  assign out_item_o.left_rev_pin  = state_q.left_rev;
  assign out_item_o.right_fwd_pin = state_q.right_fwd;
  assign out_item_o.right_rev_pin = state_q.right_rev;
  assign out_item_o.green_lamp    = state_q.green;
  assign out_item_o.red_lamp      = state_q.red;
  assign out_item_o.white_lamp    = state_q.white;
  assign out_item_o.crash_count   = state_q.crash;

endmodule

/* hw/rtl/mms_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mms_cfg_regs
// Configuration registers: light threshold and the three duty targets.
// ----------------------------------------------------------------------------
module mms_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mms_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mms_pkg::CfgDataW-1:0]  cfg_data_i,
  output mms_pkg::cfg_t                 cfg_o
);

  mms_pkg::cfg_t cfg_d, cfg_q;

  // always take writes
  assign cfg_ready_o = 1'b1;

  // decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mms_pkg::CFG_IDX_LIGHT_THRESHOLD: cfg_d.light_threshold = cfg_data_i[9:0];
        mms_pkg::CFG_IDX_SLOW_DUTY:       cfg_d.slow_duty       = cfg_data_i[7:0];
        mms_pkg::CFG_IDX_MEDIUM_DUTY:     cfg_d.medium_duty     = cfg_data_i[7:0];
        mms_pkg::CFG_IDX_FAST_DUTY:       cfg_d.fast_duty       = cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_threshold <= mms_pkg::LIGHT_THRESHOLD_RST;
      cfg_q.slow_duty       <= mms_pkg::SLOW_DUTY_RST;
      cfg_q.medium_duty     <= mms_pkg::MEDIUM_DUTY_RST;
      cfg_q.fast_duty       <= mms_pkg::FAST_DUTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/mms_step_logic.sv */
// ----------------------------------------------------------------------------
// mms_step_logic
// One ramp tick: next mode, duty step, pins, lamps and collision count.
// ----------------------------------------------------------------------------
module mms_step_logic (
  input  mms_pkg::seq_state_t state_i,
  input  mms_pkg::in_item_t   item_i,
  input  mms_pkg::cfg_t       cfg_i,
  output mms_pkg::seq_state_t state_o
);

  logic [7:0]     target;
  logic [3:0]     pins;      // left fwd, left rev, right fwd, right rev
  logic [1:0]     color;     // green, red
  mms_pkg::mode_e mode_next;
  logic           is_off;
  logic [7:0]     duty_step;

  // per-mode target, pins, color and successor
  always_comb begin
    case (state_i.mode)
      mms_pkg::MODE_SLOW: begin
        target = cfg_i.slow_duty;   pins = 4'b1010; color = 2'b10;
        mode_next = mms_pkg::MODE_MEDIUM;  is_off = 1'b0;
      end
      mms_pkg::MODE_MEDIUM: begin
        target = cfg_i.medium_duty; pins = 4'b1010; color = 2'b10;
        mode_next = mms_pkg::MODE_FAST;    is_off = 1'b0;
      end
      mms_pkg::MODE_FAST: begin
        target = cfg_i.fast_duty;   pins = 4'b1010; color = 2'b10;
        mode_next = mms_pkg::MODE_REVERSE; is_off = 1'b0;
      end
      mms_pkg::MODE_REVERSE: begin
        target = cfg_i.slow_duty;   pins = 4'b0101; color = 2'b01;
        mode_next = mms_pkg::MODE_TURN_A;  is_off = 1'b0;
      end
      mms_pkg::MODE_TURN_A: begin
        target = cfg_i.slow_duty;   pins = 4'b0010; color = 2'b10;
        mode_next = mms_pkg::MODE_TURN_B;  is_off = 1'b0;
      end
      mms_pkg::MODE_TURN_B: begin
        target = cfg_i.slow_duty;   pins = 4'b1000; color = 2'b10;
        mode_next = mms_pkg::MODE_OFF;     is_off = 1'b0;
      end
      mms_pkg::MODE_OFF: begin
        target = 8'd0;              pins = 4'b1010; color = 2'b00;
        mode_next = mms_pkg::MODE_SLOW;    is_off = 1'b1;
      end
      default: begin
        // unreachable code seven: off, and a press wraps to off
        target = 8'd0;              pins = 4'b1010; color = 2'b00;
        mode_next = mms_pkg::MODE_OFF;     is_off = 1'b1;
      end
    endcase
  end

  // step the duty one toward the target, or clear it in off
  always_comb begin
    if (is_off) begin
      duty_step = 8'd0;
    end else if (state_i.duty > target) begin
      duty_step = state_i.duty - 8'd1;
    end else if (state_i.duty < target) begin
      duty_step = state_i.duty + 8'd1;
    end else begin
      duty_step = state_i.duty;
    end
  end

  // assemble the next state
  always_comb begin
    state_o = state_i;
    if (item_i.stop_switch) begin
      state_o.mode  = mms_pkg::MODE_OFF;
      state_o.white = 1'b0;
    end else begin
      state_o.duty      = duty_step;
      state_o.mode      = (item_i.advance_press && (duty_step == target)) ?
                          mode_next : state_i.mode;
      state_o.left_fwd  = pins[3];
      state_o.left_rev  = pins[2];
      state_o.right_fwd = pins[1];
      state_o.right_rev = pins[0];
      state_o.green     = color[1];
      state_o.red       = color[0];
      state_o.white     = (item_i.light_level < cfg_i.light_threshold);
      if (item_i.collision_event) begin
        state_o.crash = state_i.crash + 16'd1;
      end
    end
  end

endmodule

/* hw/rtl/mms_checker.sv */
// ----------------------------------------------------------------------------
// mms_checker
// Port-level checks of the motor mode sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module mms_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mms_pkg::out_item_t out_item_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // every input transfer leads to a valid result through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("result missing two cycles after input transfer");

  // input backpressure only while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // reverse pins and red lamp move together, and red and green never light together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.red_lamp == out_item_o.left_rev_pin) &&
                    (out_item_o.left_rev_pin == out_item_o.right_rev_pin) &&
                    !(out_item_o.red_lamp && out_item_o.green_lamp))
    else $error("pins and lamps inconsistent");

endmodule

bind motor_mode_sequencer_with_ramp_core mms_checker u_mms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

/* sim/motor_mode_sequencer_with_ramp_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_mode_sequencer_with_ramp_core_tb
// Self-checking bench for the motor mode sequencer. A short table of directed
// ticks walks every mode, the ramp in both directions, stop and the threshold
// edges. Random ticks follow under several register settings. Every result
// is matched against a cycle-free model of the sequencer kept in the bench,
// while both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module motor_mode_sequencer_with_ramp_core_tb;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int NUM_PLAN_ROWS  = 22;
  localparam int NUM_PHASES     = 6;
  localparam int HOLD_AT_TICK   = 280;
  localparam int HOLD_CYCLES    = 90;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  // index past the last register; writes to it must be dropped
  localparam logic [mms_pkg::CfgIdxW-1:0] CFG_IDX_UNUSED = '1;

  // one row of the directed table: a register write or a tick
  typedef struct packed {
    logic                         is_write;
    logic [mms_pkg::CfgIdxW-1:0]  reg_idx;
    logic [mms_pkg::CfgDataW-1:0] reg_data;
    mms_pkg::in_item_t            stim;
    logic                         typed;
    mms_pkg::out_item_t           want;
  } plan_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  mms_pkg::in_item_t            in_item = '0;
  logic                         out_valid;
  logic                         rx_ready = 1'b0;
  logic                         hold_off = 1'b0;
  logic                         out_ready;
  mms_pkg::out_item_t           out_item;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [mms_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [mms_pkg::CfgDataW-1:0] cfg_data = '0;

  // sequencer model state and its copy of the registers
  mms_pkg::seq_state_t seq_now;
  mms_pkg::cfg_t       cfg_now;
  mms_pkg::out_item_t  awaited_status[$];

  plan_row_t plan [NUM_PLAN_ROWS];
  int src_run = 0;
  int sink_run = 0;
  int ticks_sent = 0;
  int reg_writes = 0;
  int mode_steps = 0;
  int stop_ticks = 0;
  int checked = 0;
  int mismatches = 0;
  int cycle_count = 0;

  assign out_ready = rx_ready & ~hold_off;

  motor_mode_sequencer_with_ramp_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the model by one tick and return the status it shows afterwards.
  function automatic mms_pkg::out_item_t step_sequencer(input mms_pkg::in_item_t t);
    logic [7:0] goal;
    if (t.stop_switch) begin
      // drop to off and darken white; pins, duty, green and red hold
      seq_now.mode  = mms_pkg::MODE_OFF;
      seq_now.white = 1'b0;
      stop_ticks++;
    end else begin
      // drive pins and color lamps for the mode held at the start of the tick
      case (seq_now.mode)
        mms_pkg::MODE_SLOW, mms_pkg::MODE_MEDIUM, mms_pkg::MODE_FAST: begin
          {seq_now.left_fwd, seq_now.left_rev, seq_now.right_fwd, seq_now.right_rev} = 4'b1010;
          {seq_now.green, seq_now.red} = 2'b10;
          goal = (seq_now.mode == mms_pkg::MODE_SLOW)   ? cfg_now.slow_duty :
                 (seq_now.mode == mms_pkg::MODE_MEDIUM) ? cfg_now.medium_duty :
                 cfg_now.fast_duty;
        end
        mms_pkg::MODE_REVERSE: begin
          {seq_now.left_fwd, seq_now.left_rev, seq_now.right_fwd, seq_now.right_rev} = 4'b0101;
          {seq_now.green, seq_now.red} = 2'b01;
          goal = cfg_now.slow_duty;
        end
        mms_pkg::MODE_TURN_A: begin
          {seq_now.left_fwd, seq_now.left_rev, seq_now.right_fwd, seq_now.right_rev} = 4'b0010;
          {seq_now.green, seq_now.red} = 2'b10;
          goal = cfg_now.slow_duty;
        end
        mms_pkg::MODE_TURN_B: begin
          {seq_now.left_fwd, seq_now.left_rev, seq_now.right_fwd, seq_now.right_rev} = 4'b1000;
          {seq_now.green, seq_now.red} = 2'b10;
          goal = cfg_now.slow_duty;
        end
        default: begin
          {seq_now.left_fwd, seq_now.left_rev, seq_now.right_fwd, seq_now.right_rev} = 4'b1010;
          {seq_now.green, seq_now.red} = 2'b00;
          goal = 8'd0;
        end
      endcase
      // force off to zero at once, otherwise ramp one step toward the goal
      if (seq_now.mode == mms_pkg::MODE_OFF) seq_now.duty = 8'd0;
      else if (seq_now.duty > goal) seq_now.duty = seq_now.duty - 8'd1;
      else if (seq_now.duty < goal) seq_now.duty = seq_now.duty + 8'd1;
      // a press only counts once the goal is reached after this step
      if (t.advance_press && seq_now.duty == goal) begin
        seq_now.mode = (seq_now.mode == mms_pkg::MODE_TURN_B) ? mms_pkg::MODE_OFF :
                       mms_pkg::mode_e'(seq_now.mode + 3'd1);
        mode_steps++;
      end
      seq_now.white = (t.light_level < cfg_now.light_threshold);
      if (t.collision_event) seq_now.crash = seq_now.crash + 16'd1;
    end
    // state and result share the same field layout
    return mms_pkg::out_item_t'(seq_now);
  endfunction

  function automatic string show_status(input mms_pkg::out_item_t s);
    return $sformatf("mode %0d duty %0d lf%0b lr%0b rf%0b rr%0b g%0b r%0b w%0b crash %0d",
                     s.drive_mode, s.duty_level, s.left_fwd_pin, s.left_rev_pin,
                     s.right_fwd_pin, s.right_rev_pin, s.green_lamp, s.red_lamp,
                     s.white_lamp, s.crash_count);
  endfunction

  function automatic plan_row_t tk(input bit stop, press, crash, input logic [9:0] light);
    plan_row_t r;
    r = '0;
    r.stim = '{stop_switch: stop, advance_press: press, collision_event: crash,
               light_level: light};
    return r;
  endfunction

  function automatic plan_row_t wr(input logic [mms_pkg::CfgIdxW-1:0] idx,
                                   input logic [mms_pkg::CfgDataW-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // pins are {lf, lr, rf, rr}, lamps are {green, red, white}
  function automatic plan_row_t with_result(input plan_row_t r, input mms_pkg::mode_e m,
                                            input logic [7:0] duty, input logic [3:0] pins,
                                            input logic [2:0] lamps, input logic [15:0] crash);
    r.typed = 1'b1;
    r.want  = '{drive_mode: m, duty_level: duty,
                left_fwd_pin: pins[3], left_rev_pin: pins[2],
                right_fwd_pin: pins[1], right_rev_pin: pins[0],
                green_lamp: lamps[2], red_lamp: lamps[1], white_lamp: lamps[0],
                crash_count: crash};
    return r;
  endfunction

  // Draw the idle cycles before the next transfer; now and then run a burst
  // with no idling at all.
  task automatic pick_gap(inout int run_left, output int gap);
    if (run_left > 0) begin
      run_left--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(8, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 13);
    end
  endtask

  // Offer one tick, hold it until the transfer, then queue its status.
  task automatic offer_tick(input mms_pkg::in_item_t t, input logic typed,
                            input mms_pkg::out_item_t want);
    int gap;
    mms_pkg::out_item_t guess;
    pick_gap(src_run, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= t;
    do @(posedge clk); while (!in_ready);
    guess = step_sequencer(t);
    awaited_status.push_back(typed ? want : guess);
    ticks_sent++;
  endtask

  // Drop the input and wait until every queued status has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_valid after the last write.
  task automatic write_reg(input logic [mms_pkg::CfgIdxW-1:0] idx,
                           input logic [mms_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mms_pkg::CFG_IDX_LIGHT_THRESHOLD: cfg_now.light_threshold = data[9:0];
      mms_pkg::CFG_IDX_SLOW_DUTY:       cfg_now.slow_duty       = data[7:0];
      mms_pkg::CFG_IDX_MEDIUM_DUTY:     cfg_now.medium_duty     = data[7:0];
      mms_pkg::CFG_IDX_FAST_DUTY:       cfg_now.fast_duty       = data[7:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Load all four registers, with junk in the unused upper data bits.
  task automatic configure(input logic [9:0] thr, input logic [7:0] lo_duty, mid_duty,
                           hi_duty);
    logic [mms_pkg::CfgDataW-1:0] junk;
    junk = mms_pkg::CfgDataW'($urandom);
    write_reg(mms_pkg::CFG_IDX_LIGHT_THRESHOLD, {junk[15:10], thr});
    write_reg(mms_pkg::CFG_IDX_SLOW_DUTY, {junk[15:8], lo_duty});
    write_reg(mms_pkg::CFG_IDX_MEDIUM_DUTY, {junk[7:0], mid_duty});
    write_reg(mms_pkg::CFG_IDX_FAST_DUTY, {junk[11:4], hi_duty});
    cfg_valid <= 1'b0;
  endtask

  // Random tick: mostly running with frequent presses, light often right at
  // the threshold edge, and an occasional stop.
  function automatic mms_pkg::in_item_t random_tick();
    mms_pkg::in_item_t t;
    int pick;
    t.stop_switch     = ($urandom_range(0, 15) == 0);
    t.advance_press   = ($urandom_range(0, 2) != 0);
    t.collision_event = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 7);
    if (pick == 0) t.light_level = cfg_now.light_threshold;
    else if (pick == 1) t.light_level = cfg_now.light_threshold - 10'd1;
    else t.light_level = 10'($urandom);
    return t;
  endfunction

  // Compare every result transfer with the oldest queued status.
  always @(posedge clk) begin : check_results
    mms_pkg::out_item_t want;
    bit differ;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with nothing queued: %s", $time, show_status(out_item));
      end else begin
        want = awaited_status.pop_front();
        checked++;
        differ = (out_item.drive_mode    !== want.drive_mode)    ||
                 (out_item.duty_level    !== want.duty_level)    ||
                 (out_item.left_fwd_pin  !== want.left_fwd_pin)  ||
                 (out_item.left_rev_pin  !== want.left_rev_pin)  ||
                 (out_item.right_fwd_pin !== want.right_fwd_pin) ||
                 (out_item.right_rev_pin !== want.right_rev_pin) ||
                 (out_item.green_lamp    !== want.green_lamp)    ||
                 (out_item.red_lamp      !== want.red_lamp)      ||
                 (out_item.white_lamp    !== want.white_lamp)    ||
                 (out_item.crash_count   !== want.crash_count);
        if (differ) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch on result %0d", $time, checked);
            $display("  expected %s", show_status(want));
            $display("  actual   %s", show_status(out_item));
          end
        end
      end
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results still queued",
               cycle_count, awaited_status.size());
      $display("motor_mode_sequencer_with_ramp_core_tb NOT OK");
      $finish;
    end
  end

  // Receiver: idle a random number of cycles before each result transfer.
  initial begin : sink
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      pick_gap(sink_run, gap);
      if (gap > 0) begin
        rx_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rx_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Hold the output off for a long stretch mid-run so the core backs up.
  initial begin : long_hold
    do @(posedge clk); while (ticks_sent < HOLD_AT_TICK);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    // model state after reset
    seq_now = '0;
    seq_now.mode  = mms_pkg::MODE_OFF;
    seq_now.white = 1'b1;
    cfg_now = '{light_threshold: mms_pkg::LIGHT_THRESHOLD_RST,
                slow_duty: mms_pkg::SLOW_DUTY_RST,
                medium_duty: mms_pkg::MEDIUM_DUTY_RST,
                fast_duty: mms_pkg::FAST_DUTY_RST};

    // Directed walk: stop out of reset, off to slow on one press, threshold
    // edges, ramp down after a target write, a dropped write past the last
    // register, every mode in turn with the wrap back to off, stop mid-run.
    plan = '{
      with_result(tk(1, 1, 1, 10'd0),    mms_pkg::MODE_OFF,  8'd0, 4'b0000, 3'b000, 16'd0),
      with_result(tk(0, 0, 0, 10'd1023), mms_pkg::MODE_OFF,  8'd0, 4'b1010, 3'b000, 16'd0),
      with_result(tk(0, 1, 1, 10'd0),    mms_pkg::MODE_SLOW, 8'd0, 4'b1010, 3'b001, 16'd1),
      tk(0, 1, 0, 10'd549),
      tk(0, 0, 0, 10'd550),
      tk(0, 0, 1, 10'd1023),
      wr(mms_pkg::CFG_IDX_SLOW_DUTY,   16'hFF02),
      wr(mms_pkg::CFG_IDX_MEDIUM_DUTY, 16'h0003),
      wr(mms_pkg::CFG_IDX_FAST_DUTY,   16'hAA01),
      wr(CFG_IDX_UNUSED,               16'hFFFF),
      tk(0, 1, 0, 10'd100),
      tk(0, 1, 1, 10'd600),
      tk(0, 1, 0, 10'd0),
      tk(0, 1, 0, 10'd1023),
      tk(0, 1, 1, 10'd300),
      tk(0, 1, 0, 10'd800),
      tk(0, 1, 0, 10'd512),
      tk(0, 0, 1, 10'd511),
      tk(0, 1, 0, 10'd2),
      tk(0, 0, 0, 10'd700),
      tk(1, 1, 1, 10'd5),
      tk(0, 0, 0, 10'd1000)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
        if (i == NUM_PLAN_ROWS - 1 || !plan[i + 1].is_write) cfg_valid <= 1'b0;
      end else begin
        offer_tick(plan[i].stim, plan[i].typed, plan[i].want);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: configure(mms_pkg::LIGHT_THRESHOLD_RST, mms_pkg::SLOW_DUTY_RST,
                     mms_pkg::MEDIUM_DUTY_RST, mms_pkg::FAST_DUTY_RST);
        1: configure(10'd0, 8'd3, 8'd5, 8'd7);
        2: configure(10'd1023, 8'd0, 8'd1, 8'd255);
        4: configure(10'd512, 8'd255, 8'd254, 8'd0);
        default: configure(10'($urandom), 8'($urandom_range(0, 6)),
                           8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
      endcase
      repeat ((ph == 1) ? 100 : (ph == 3) ? 120 : (ph == 4) ? 50 : 60)
        offer_tick(random_tick(), 1'b0, '0);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_status.size() != 0) begin
      $display("%0d results never arrived", awaited_status.size());
      mismatches += awaited_status.size();
    end

    $display("sent %0d ticks (%0d stopped) with %0d register writes over %0d settings",
             ticks_sent, stop_ticks, reg_writes, NUM_PHASES + 1);
    $display("checked %0d results, %0d mode advances, %0d mismatches",
             checked, mode_steps, mismatches);
    if (mismatches == 0) begin
      $display("motor_mode_sequencer_with_ramp_core_tb OK");
    end else begin
      $display("motor_mode_sequencer_with_ramp_core_tb NOT OK");
    end
    $finish;
  end

endmodule
